FILE: hw/rtl/bdse_pkg.sv
// Shared types, constants and helpers for the block delta shift encoder.
`timescale 1ns / 1ps

package bdse_pkg;

  localparam int NUM_LANES   = 4;
  localparam int LANE_W      = 16;
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = 5;
  localparam int CNT_W       = 6;
  localparam int AXES_W      = 3;
  localparam int SHIFT_W     = 3;
  localparam int DCNT_W      = 5;
  localparam int DELTA_LIMIT = 127;
  localparam int TOP_SHIFT   = 7;

  // Smallest magnitude that still overflows at the top shift
  localparam logic [LANE_W-1:0] OVF_LIMIT = LANE_W'((DELTA_LIMIT + 1) << TOP_SHIFT);

  localparam logic ROW_ANCHOR = 1'b0;
  localparam logic ROW_DELTA  = 1'b1;

  typedef logic [LANE_W-1:0] lane_t;
  typedef lane_t [NUM_LANES-1:0] sample_t;

  typedef struct packed {
    logic [LANE_W-1:0] max_abs;
    logic              ovf;
    sample_t           shifted;
  } delta_res_t;

  // Pick the smallest shift that brings a magnitude down to the delta limit
  function automatic logic [SHIFT_W-1:0] shift_for(input logic [LANE_W-1:0] m);
    logic [SHIFT_W-1:0] r;
    r = SHIFT_W'(TOP_SHIFT);
    for (int s = TOP_SHIFT; s >= 0; s--) begin
      if ((m >> s) <= LANE_W'(DELTA_LIMIT)) r = SHIFT_W'(s);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/bdse_store.sv
// Sample store: one write port, one registered read port.
`timescale 1ns / 1ps

module bdse_store import bdse_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  sample_t           wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output sample_t           rd_data
);

  sample_t mem [STORE_DEPTH];

  // Write a sample
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/bdse_delta.sv
// Lane deltas: magnitude maximum, overflow check and shifted int8 deltas.
`timescale 1ns / 1ps

module bdse_delta import bdse_pkg::*; (
  input  sample_t              cur,
  input  sample_t              prev,
  input  logic [NUM_LANES-1:0] lane_mask,
  input  logic [SHIFT_W-1:0]   shift,
  output delta_res_t           res
);

  always_comb begin
    logic signed [LANE_W:0] d;
    logic signed [LANE_W:0] q;
    logic        [LANE_W:0] mag;
    res = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      // Widen by one bit so the difference never wraps
      d   = $signed({cur[i][LANE_W-1], cur[i]}) - $signed({prev[i][LANE_W-1], prev[i]});
      mag = d[LANE_W] ? unsigned'(-d) : unsigned'(d);
      q   = d >>> shift;
      if (lane_mask[i]) begin
        if (mag[LANE_W-1:0] > res.max_abs) res.max_abs = mag[LANE_W-1:0];
        if (mag[LANE_W-1:0] >= OVF_LIMIT) res.ovf = 1'b1;
        // Keep the low byte, sign extended
        res.shifted[i] = {{(LANE_W-8){q[7]}}, q[7:0]};
      end
    end
  end

endmodule

FILE: hw/rtl/block_delta_shift_encoder_top.sv
// Top level: request intake, flush sequencer and row output register.
`timescale 1ns / 1ps
// A request that does not flush only stores its sample; busy stays low.
// A flushing request runs per block a scan pass, which may cut the block
// short, and an emit pass, both limited by the store's single read port;
// rows leave one per cycle during emit. Results cannot be stalled.
// Synchronous reset clears the held sample count and sets active_axes to 3.

module block_delta_shift_encoder_top import bdse_pkg::*; #(
  parameter int MAX_LANES  = 4,
  parameter int MAX_DELTAS = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [LANE_W-1:0] in_lane_0,
  input  logic signed [LANE_W-1:0] in_lane_1,
  input  logic signed [LANE_W-1:0] in_lane_2,
  input  logic signed [LANE_W-1:0] in_lane_3,
  input  logic                     in_end_of_chunk,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [AXES_W-1:0]        cfg_active_axes,
  output logic                     out_valid,
  output logic                     out_row_kind,
  output logic [SHIFT_W-1:0]       out_shift,
  output logic [DCNT_W-1:0]        out_delta_count,
  output logic signed [LANE_W-1:0] out_value_0,
  output logic signed [LANE_W-1:0] out_value_1,
  output logic signed [LANE_W-1:0] out_value_2,
  output logic signed [LANE_W-1:0] out_value_3,
  output logic                     out_block_last,
  output logic                     out_run_last
);

  localparam logic [CNT_W-1:0]  BLK_CAP   = CNT_W'(MAX_DELTAS + 1);
  localparam logic [AXES_W-1:0] LANE_CAP  = AXES_W'(MAX_LANES);
  localparam logic [CNT_W-1:0]  LAST_SLOT = CNT_W'(STORE_DEPTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t              state_r, state_nxt;
  logic [AXES_W-1:0]   axes_r, axes_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    src_r, src_nxt;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [LANE_W-1:0]   max_r, max_nxt;
  sample_t             prev_r, prev_nxt;

  logic                ov_valid_r, ov_valid_nxt;
  logic                ov_kind_r, ov_kind_nxt;
  logic [SHIFT_W-1:0]  ov_shift_r, ov_shift_nxt;
  logic [DCNT_W-1:0]   ov_dcnt_r, ov_dcnt_nxt;
  sample_t             ov_vals_r, ov_vals_nxt;
  logic                ov_blast_r, ov_blast_nxt;
  logic                ov_rlast_r, ov_rlast_nxt;

  logic                 accept;
  logic                 wr_en;
  sample_t              wr_data;
  logic [ADDR_W-1:0]    rd_addr;
  sample_t              rd_data;
  logic [AXES_W-1:0]    lanes;
  logic [NUM_LANES-1:0] lane_mask;
  logic [SHIFT_W-1:0]   cur_shift;
  delta_res_t           dres;
  logic [CNT_W-1:0]     src_end;
  logic [CNT_W-1:0]     left;

  // Lanes in use, clamped to the lane count
  assign lanes = (axes_r > LANE_CAP) ? LANE_CAP : axes_r;
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_mask[i] = (AXES_W'(i) < lanes);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign wr_en   = accept;
  assign wr_data = {in_lane_3, in_lane_2, in_lane_1, in_lane_0};
  assign rd_addr = ADDR_W'(src_r + iss_r);

  assign cur_shift = shift_for(max_r);
  assign src_end   = src_r + lim_r;
  assign left      = total_r - src_end;

  bdse_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (held_r[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bdse_delta u_delta (
    .cur       (rd_data),
    .prev      (prev_r),
    .lane_mask (lane_mask),
    .shift     (cur_shift),
    .res       (dres)
  );

  // Sequencer: intake, scan pass and emit pass
  always_comb begin
    state_nxt    = state_r;
    axes_nxt     = axes_r;
    held_nxt     = held_r;
    total_nxt    = total_r;
    src_nxt      = src_r;
    lim_nxt      = lim_r;
    iss_nxt      = iss_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = iss_r;
    max_nxt      = max_r;
    prev_nxt     = prev_r;
    ov_valid_nxt = 1'b0;
    ov_kind_nxt  = ov_kind_r;
    ov_shift_nxt = ov_shift_r;
    ov_dcnt_nxt  = ov_dcnt_r;
    ov_vals_nxt  = ov_vals_r;
    ov_blast_nxt = ov_blast_r;
    ov_rlast_nxt = ov_rlast_r;

    if (cfg_valid && cfg_ready) axes_nxt = cfg_active_axes;

    // Issue the next read of the current block
    if ((state_r != ST_IDLE) && (iss_r < lim_r)) begin
      rd_vld_nxt = 1'b1;
      iss_nxt    = iss_r + 1'b1;
    end
    if (rd_vld_r) prev_nxt = rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((held_r == LAST_SLOT) || in_end_of_chunk) begin
            total_nxt = held_r + 1'b1;
            src_nxt   = '0;
            lim_nxt   = (held_r + 1'b1 > BLK_CAP) ? BLK_CAP : held_r + 1'b1;
            iss_nxt   = '0;
            max_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            held_nxt = held_r + 1'b1;
          end
        end
      end

      ST_SCAN: begin
        if (rd_vld_r) begin
          if (rd_idx_r != '0) begin
            if (dres.max_abs > max_r) max_nxt = dres.max_abs;
          end
          // Cut the block before a delta that overflows even at the top shift
          if ((rd_idx_r != '0) && dres.ovf) begin
            lim_nxt    = rd_idx_r;
            iss_nxt    = '0;
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_EMIT;
          end else if (rd_idx_r == lim_r - 1'b1) begin
            iss_nxt    = '0;
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (rd_vld_r) begin
          ov_valid_nxt = 1'b1;
          ov_shift_nxt = cur_shift;
          ov_dcnt_nxt  = DCNT_W'(lim_r - 1'b1);
          ov_blast_nxt = (rd_idx_r == lim_r - 1'b1);
          ov_rlast_nxt = (rd_idx_r == lim_r - 1'b1) && (src_end == total_r);
          if (rd_idx_r == '0) begin
            ov_kind_nxt = ROW_ANCHOR;
            for (int i = 0; i < NUM_LANES; i++) begin
              ov_vals_nxt[i] = lane_mask[i] ? rd_data[i] : '0;
            end
          end else begin
            ov_kind_nxt = ROW_DELTA;
            ov_vals_nxt = dres.shifted;
          end
          // Advance to the next block, or finish the flush
          if (rd_idx_r == lim_r - 1'b1) begin
            src_nxt    = src_end;
            iss_nxt    = '0;
            rd_vld_nxt = 1'b0;
            max_nxt    = '0;
            if (src_end == total_r) begin
              held_nxt  = '0;
              state_nxt = ST_IDLE;
            end else begin
              lim_nxt   = (left > BLK_CAP) ? BLK_CAP : left;
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      axes_r     <= AXES_W'(3);
      held_r     <= '0;
      total_r    <= '0;
      src_r      <= '0;
      lim_r      <= '0;
      iss_r      <= '0;
      rd_vld_r   <= 1'b0;
      ov_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      axes_r     <= axes_nxt;
      held_r     <= held_nxt;
      total_r    <= total_nxt;
      src_r      <= src_nxt;
      lim_r      <= lim_nxt;
      iss_r      <= iss_nxt;
      rd_vld_r   <= rd_vld_nxt;
      ov_valid_r <= ov_valid_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    max_r      <= max_nxt;
    prev_r     <= prev_nxt;
    ov_kind_r  <= ov_kind_nxt;
    ov_shift_r <= ov_shift_nxt;
    ov_dcnt_r  <= ov_dcnt_nxt;
    ov_vals_r  <= ov_vals_nxt;
    ov_blast_r <= ov_blast_nxt;
    ov_rlast_r <= ov_rlast_nxt;
  end

  assign out_valid       = ov_valid_r;
  assign out_row_kind    = ov_kind_r;
  assign out_shift       = ov_shift_r;
  assign out_delta_count = ov_dcnt_r;
  assign out_value_0     = ov_vals_r[0];
  assign out_value_1     = ov_vals_r[1];
  assign out_value_2     = ov_vals_r[2];
  assign out_value_3     = ov_vals_r[3];
  assign out_block_last  = ov_blast_r;
  assign out_run_last    = ov_rlast_r;

endmodule
